// ===== src/bde_pkg.sv =====
package bde_pkg;

  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SLOT_W      = 3;

  // two event slots per lane, then the chord slot
  localparam logic [SLOT_W-1:0] CHORD_SLOT = 3'd6;

  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHORD    = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd800;
  localparam logic [CFG_W-1:0] CHORD_RESET    = 16'd3000;

  localparam logic [1:0] BTN_UP     = 2'd0;
  localparam logic [1:0] BTN_DOWN   = 2'd1;
  localparam logic [1:0] BTN_ACTION = 2'd2;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_CHORD   = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_POP
  } state_t;

  // events found by one lane during a poll, in queue order
  typedef struct packed {
    logic [1:0]        vld;
    ev_kind_t          k0;
    ev_kind_t          k1;
    logic [TIME_W-1:0] dur;
  } lane_ev_t;

  // one queue entry
  typedef struct packed {
    logic [1:0]        button;
    ev_kind_t          kind;
    logic [TIME_W-1:0] dur;
  } queue_ev_t;

endpackage

// ===== src/bde_ram.sv =====
module bde_ram #(
  parameter int unsigned WIDTH = 37,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bde_lane.sv =====
module bde_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      lvl,
  input  logic [bde_pkg::TIME_W-1:0] now,
  input  logic [bde_pkg::CFG_W-1:0]  deb_time,
  input  logic [bde_pkg::CFG_W-1:0]  long_time,
  output logic                      stable,
  output logic [bde_pkg::TIME_W-1:0] press_start,
  output bde_pkg::lane_ev_t         ev
);
  import bde_pkg::*;

  logic              last_raw;
  logic [TIME_W-1:0] change_time;
  logic              long_rep;

  logic              stable_next;
  logic              last_raw_next;
  logic [TIME_W-1:0] change_time_next;
  logic [TIME_W-1:0] press_start_next;
  logic              long_rep_next;
  lane_ev_t          ev_next;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] held;

  assign since_change = now - change_time;
  assign held         = now - press_start;

  always_comb begin
    stable_next      = stable;
    last_raw_next    = last_raw;
    change_time_next = change_time;
    press_start_next = press_start;
    long_rep_next    = long_rep;
    ev_next          = '{vld: 2'b00, k0: EV_PRESS, k1: EV_PRESS, dur: '0};
    if (lvl != last_raw) begin
      // raw edge restarts the debounce timer
      last_raw_next    = lvl;
      change_time_next = now;
    end else if (since_change >= TIME_W'(deb_time)) begin
      if (lvl != stable) begin
        stable_next = lvl;
        if (lvl) begin
          press_start_next = now;
          long_rep_next    = 1'b0;
          ev_next.vld[0]   = 1'b1;
          ev_next.k0       = EV_PRESS;
          // zero long time fires in the same poll, held time is zero
          if (long_time == '0) begin
            long_rep_next  = 1'b1;
            ev_next.vld[1] = 1'b1;
            ev_next.k1     = EV_LONG;
          end
        end else begin
          ev_next.vld[0] = 1'b1;
          ev_next.k0     = EV_RELEASE;
          ev_next.dur    = held;
          if (!long_rep) begin
            ev_next.vld[1] = 1'b1;
            ev_next.k1     = EV_SHORT;
          end
        end
      end else if (stable && !long_rep && held >= TIME_W'(long_time)) begin
        long_rep_next  = 1'b1;
        ev_next.vld[0] = 1'b1;
        ev_next.k0     = EV_LONG;
        ev_next.dur    = held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      last_raw    <= 1'b0;
      change_time <= '0;
      press_start <= '0;
      long_rep    <= 1'b0;
      ev          <= '{vld: 2'b00, k0: EV_PRESS, k1: EV_PRESS, dur: '0};
    end else if (load) begin
      stable      <= stable_next;
      last_raw    <= last_raw_next;
      change_time <= change_time_next;
      press_start <= press_start_next;
      long_rep    <= long_rep_next;
      ev          <= ev_next;
    end
  end

endmodule

// ===== src/bde_merge.sv =====
module bde_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [bde_pkg::SLOT_W-1:0]  slot,
  input  bde_pkg::lane_ev_t           lane_ev [bde_pkg::NUM_BUTTONS],
  input  logic [bde_pkg::TIME_W-1:0]  now,
  input  logic                        up_stable,
  input  logic                        dn_stable,
  input  logic [bde_pkg::TIME_W-1:0]  up_start,
  input  logic [bde_pkg::TIME_W-1:0]  dn_start,
  input  logic [bde_pkg::CFG_W-1:0]   chord_time,
  output logic                        push_vld,
  output bde_pkg::queue_ev_t          push_data
);
  import bde_pkg::*;

  logic              chord_rep;
  logic              both;
  logic              chord_hit;
  logic [TIME_W-1:0] du;
  logic [TIME_W-1:0] dd;
  lane_ev_t          sel;
  logic              sel_lane;

  assign both      = up_stable && dn_stable;
  assign du        = now - up_start;
  assign dd        = now - dn_start;
  assign chord_hit = both && !chord_rep &&
                     du >= TIME_W'(chord_time) && dd >= TIME_W'(chord_time);

  always_comb begin
    sel      = lane_ev[0];
    sel_lane = 1'b1;
    case (slot[SLOT_W-1:1])
      2'd0: sel = lane_ev[0];
      2'd1: sel = lane_ev[1];
      2'd2: sel = lane_ev[2];
      default: sel_lane = 1'b0;
    endcase
  end

  always_comb begin
    push_vld  = 1'b0;
    push_data = '{button: BTN_UP, kind: EV_PRESS, dur: '0};
    if (sel_lane) begin
      push_vld         = sel.vld[slot[0]];
      push_data.button = slot[SLOT_W-1:1];
      push_data.kind   = slot[0] ? sel.k1 : sel.k0;
      push_data.dur    = sel.dur;
    end else if (slot == CHORD_SLOT) begin
      push_vld         = chord_hit;
      push_data.button = BTN_UP;
      push_data.kind   = EV_CHORD;
      push_data.dur    = (du < dd) ? du : dd;
    end
  end

  // chord flag re-arms once either button is stably released
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_rep <= 1'b0;
    end else if (step && slot == CHORD_SLOT) begin
      chord_rep <= both && (chord_rep || chord_hit);
    end
  end

endmodule

// ===== src/button_debounce_event_queue.sv =====
// Debounces three buttons (up, down, action) and queues press, release,
// short, long and up+down chord events; func selects a poll (time plus raw
// levels, no result) or a pop (one result: the oldest event, or valid_res 0
// when the queue is empty). The queue keeps at most QUEUE_DEPTH-1 events and
// drops new ones when full. One lane per button evaluates its timers in the
// accept cycle; a poll then keeps the block busy in ST_EMIT, since its up to
// seven events (two per lane plus the chord) go through the single write port
// of the event RAM one slot per cycle. A pop of a non-empty queue goes through
// the registered RAM read and ST_POP before the result is loaded; an empty pop
// loads the result directly. The result sits in an output register; polls are
// still taken while it waits, pops wait until it has been taken. Configuration
// writes are always ready and apply at once.
module button_debounce_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [31:0]                   now_ms,
  input  logic [2:0]                    raw_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          valid_res,
  output logic [1:0]                    button,
  output logic [2:0]                    event_kind,
  output logic [31:0]                   hold_ms,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import bde_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned EV_W  = $bits(queue_ev_t);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0] deb_time;
  logic [CFG_W-1:0] long_time;
  logic [CFG_W-1:0] chord_time;

  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr_inc;
  logic [PTR_W-1:0]  rd_ptr_inc;
  logic              empty;
  logic              full;

  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] now_reg;

  logic              accept;
  logic              poll_acc;
  logic              pop_acc;
  logic              emit_step;
  logic              ram_re;
  logic              ram_we;
  logic [EV_W-1:0]   ram_rdata;
  queue_ev_t         rd_ev;

  logic              push_vld;
  queue_ev_t         push_data;

  lane_ev_t          lane_ev     [NUM_BUTTONS];
  logic              lane_stable [NUM_BUTTONS];
  logic [TIME_W-1:0] lane_start  [NUM_BUTTONS];

  assign cfg_ready = 1'b1;

  assign accept   = in_valid && in_ready;
  assign poll_acc = accept && func == FUNC_POLL;
  assign pop_acc  = accept && func == FUNC_POP;

  assign wr_ptr_inc = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign empty      = wr_ptr == rd_ptr;
  assign full       = wr_ptr_inc == rd_ptr;
  assign ram_we     = emit_step && push_vld && !full;
  assign rd_ev      = queue_ev_t'(ram_rdata);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (poll_acc) begin
          state_next = ST_EMIT;
        end else if (pop_acc && !empty) begin
          state_next = ST_POP;
        end
      end
      ST_EMIT: begin
        if (slot == CHORD_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    emit_step = 1'b0;
    ram_re    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !out_valid || func == FUNC_POLL;
        ram_re   = pop_acc && !empty;
      end
      ST_EMIT: emit_step = 1'b1;
      ST_POP:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deb_time   <= DEBOUNCE_RESET;
      long_time  <= LONG_RESET;
      chord_time <= CHORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE: deb_time   <= cfg_data;
        REG_LONG:     long_time  <= cfg_data;
        REG_CHORD:    chord_time <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (poll_acc) begin
      slot <= '0;
    end else if (emit_step) begin
      slot <= slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_acc) begin
      now_reg <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (ram_we) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (ram_re) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

  // result register, only loaded while it holds no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_acc && empty) begin
      out_valid <= 1'b1;
    end else if (state == ST_POP) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_acc && empty) begin
      valid_res  <= 1'b0;
      button     <= BTN_UP;
      event_kind <= EV_PRESS;
      hold_ms    <= '0;
    end else if (state == ST_POP) begin
      valid_res  <= 1'b1;
      button     <= rd_ev.button;
      event_kind <= rd_ev.kind;
      hold_ms    <= rd_ev.dur;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bde_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .load        (poll_acc),
      .lvl         (raw_level[i]),
      .now         (now_ms),
      .deb_time    (deb_time),
      .long_time   (long_time),
      .stable      (lane_stable[i]),
      .press_start (lane_start[i]),
      .ev          (lane_ev[i])
    );
  end

  bde_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .step       (emit_step),
    .slot       (slot),
    .lane_ev    (lane_ev),
    .now        (now_reg),
    .up_stable  (lane_stable[BTN_UP]),
    .dn_stable  (lane_stable[BTN_DOWN]),
    .up_start   (lane_start[BTN_UP]),
    .dn_start   (lane_start[BTN_DOWN]),
    .chord_time (chord_time),
    .push_vld   (push_vld),
    .push_data  (push_data)
  );

  bde_ram #(
    .WIDTH (EV_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (push_data),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

endmodule

// ===== src/bde_checker.sv =====
module bde_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          valid_res,
  input logic [1:0]                    button,
  input logic [2:0]                    event_kind,
  input logic [31:0]                   hold_ms
);
  import bde_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(button) &&
      $stable(event_kind) && $stable(hold_ms))
    else $error("result changed while stalled");

  // empty-queue result is all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> button == 2'd0 && event_kind == 3'd0 && hold_ms == '0)
    else $error("empty pop result not zero");

  // press carries no duration, chord reports the up button
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |->
      (event_kind != EV_PRESS || hold_ms == '0) &&
      (event_kind != EV_CHORD || button == BTN_UP))
    else $error("event fields inconsistent with kind");

  // a poll transaction keeps the block busy for its event slots
  a_poll_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_POLL |=> !in_ready ##1 !in_ready)
    else $error("input taken during poll processing");

endmodule

bind button_debounce_event_queue bde_checker u_bde_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .func       (func),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .valid_res  (valid_res),
  .button     (button),
  .event_kind (event_kind),
  .hold_ms    (hold_ms)
);

// ===== tb/sv/tb.sv =====
module tb;
  import bde_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic        fn;
    logic [31:0] t_ms;
    logic [2:0]  raw;
  } sent_item_t;

  typedef struct {
    logic      valid_res;
    queue_ev_t ev;
  } pop_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 func = FUNC_POLL;
  logic [31:0]          now_ms = '0;
  logic [2:0]           raw_level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 valid_res;
  logic [1:0]           button;
  logic [2:0]           event_kind;
  logic [31:0]          hold_ms;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  button_debounce_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (.*);

  // predicted block state
  logic [15:0] deb_ms    = DEBOUNCE_RESET;
  logic [15:0] long_ms   = LONG_RESET;
  logic [15:0] chord_set = CHORD_RESET;
  logic [2:0]  stable_lvl = '0;
  logic [2:0]  last_raw   = '0;
  logic [2:0]  long_done  = '0;
  logic        chord_done = 1'b0;
  logic [31:0] change_t [3] = '{default: '0};
  logic [31:0] press_t  [3] = '{default: '0};
  queue_ev_t   event_fifo [$];

  sent_item_t  items_pending [$];
  pop_result_t reads_due [$];
  int          fail_count = 0;

  // stimulus generator state
  logic [31:0] gen_now = '0;
  logic [2:0]  gen_target = '0;

  int burst_left = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int stall_mode = 0;

  initial forever #4 clk = ~clk;

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

  function automatic void queue_event(input logic [1:0] btn, input ev_kind_t kind,
                                      input logic [31:0] dur);
    queue_ev_t ev;
    ev.button = btn;
    ev.kind = kind;
    ev.dur = dur;
    // a full queue drops the new event
    if (event_fifo.size() < QUEUE_DEPTH - 1) event_fifo.push_back(ev);
  endfunction

  function automatic void debounce_poll(input logic [31:0] now, input logic [2:0] raw);
    logic [31:0] held;
    logic [31:0] du;
    logic [31:0] dd;
    for (int b = 0; b < 3; b++) begin
      if (raw[b] != last_raw[b]) begin
        last_raw[b] = raw[b];
        change_t[b] = now;
        continue;
      end
      held = now - change_t[b];
      if (held < {16'd0, deb_ms}) continue;
      if (raw[b] != stable_lvl[b]) begin
        stable_lvl[b] = raw[b];
        if (raw[b]) begin
          press_t[b] = now;
          long_done[b] = 1'b0;
          queue_event(2'(b), EV_PRESS, '0);
        end else begin
          held = now - press_t[b];
          queue_event(2'(b), EV_RELEASE, held);
          if (!long_done[b]) queue_event(2'(b), EV_SHORT, held);
        end
      end
      held = now - press_t[b];
      if (stable_lvl[b] && !long_done[b] && held >= {16'd0, long_ms}) begin
        long_done[b] = 1'b1;
        queue_event(2'(b), EV_LONG, held);
      end
    end
    if (stable_lvl[0] && stable_lvl[1]) begin
      du = now - press_t[0];
      dd = now - press_t[1];
      if (!chord_done && du >= {16'd0, chord_set} && dd >= {16'd0, chord_set}) begin
        chord_done = 1'b1;
        queue_event(BTN_UP, EV_CHORD, (du < dd) ? du : dd);
      end
    end else begin
      chord_done = 1'b0;
    end
  endfunction

  function automatic void predict_item(input logic fn, input logic [31:0] t_ms,
                                       input logic [2:0] raw);
    pop_result_t res;
    if (fn == FUNC_POLL) begin
      debounce_poll(t_ms, raw);
    end else begin
      res.valid_res = 1'b0;
      res.ev = '0;
      if (event_fifo.size() != 0) begin
        res.valid_res = 1'b1;
        res.ev = event_fifo.pop_front();
      end
      reads_due.push_back(res);
    end
  endfunction

  task automatic push_item(input logic fn, input logic [31:0] t_ms, input logic [2:0] raw);
    sent_item_t it;
    it.fn = fn;
    it.t_ms = t_ms;
    it.raw = raw;
    items_pending.push_back(it);
  endtask

  // mostly held button patterns with occasional bounce, pops at a rate that varies
  task automatic add_random(input int count);
    int pop_pct;
    int mode_left;
    int span;
    int pick;
    logic [2:0] raw;
    pop_pct = 25;
    mode_left = 0;
    for (int i = 0; i < count; i++) begin
      if (mode_left == 0) begin
        pick = $urandom_range(0, 3);
        pop_pct = (pick == 0) ? 3 : (pick == 1) ? 20 : (pick == 2) ? 45 : 80;
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if ($urandom_range(0, 99) < pop_pct) begin
        push_item(FUNC_POP, $urandom, 3'($urandom));
      end else begin
        pick = $urandom_range(0, 39);
        if (pick < 24) span = deb_ms / 2 + 1;
        else if (pick < 33) span = 2 * deb_ms + 2;
        else if (pick < 37) span = long_ms + 2;
        else span = chord_set + 2;
        gen_now += $urandom_range(0, span);
        if ($urandom_range(0, 199) == 0) gen_now = $urandom;
        if ($urandom_range(0, 11) == 0) gen_target = 3'($urandom);
        raw = gen_target;
        if ($urandom_range(0, 14) == 0) raw ^= 3'(1 << $urandom_range(0, 2));
        push_item(FUNC_POLL, gen_now, raw);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (items_pending.size() != 0 || in_valid || reads_due.size() != 0);
    // a poll keeps the block busy with nothing to show for it
    repeat (24) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last transaction
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: deb_ms = data;
      REG_LONG:     long_ms = data;
      REG_CHORD:    chord_set = data;
      default: ;
    endcase
  endtask

  task automatic set_times(input logic [15:0] d, input logic [15:0] l, input logic [15:0] c,
                           input bit spare);
    cfg_put(REG_DEBOUNCE, d);
    if (spare) cfg_put(REG_SPARE, 16'($urandom));
    cfg_put(REG_LONG, l);
    cfg_put(REG_CHORD, c);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    sent_item_t nxt;
    bit hold;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && !in_ready;
      if (in_valid && in_ready) predict_item(func, now_ms, raw_level);
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (items_pending.size() != 0) begin
          nxt = items_pending.pop_front();
          func <= nxt.fn;
          now_ms <= nxt.t_ms;
          raw_level <= nxt.raw;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    pop_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reads_due.size() == 0) begin
          $error("result transaction with no pop outstanding");
          fail_count++;
        end else begin
          want = reads_due.pop_front();
          if (valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, valid_res);
            fail_count++;
          end
          if (button !== want.ev.button) begin
            $error("button: expected %0d, got %0d", want.ev.button, button);
            fail_count++;
          end
          if (event_kind !== want.ev.kind) begin
            $error("event_kind: expected %0d, got %0d", want.ev.kind, event_kind);
            fail_count++;
          end
          if (hold_ms !== want.ev.dur) begin
            $error("hold_ms: expected %0d, got %0d", want.ev.dur, hold_ms);
            fail_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 128);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= (stall_left % 8) < 3;
      endcase
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset timing: 30 / 800 / 3000
    push_item(FUNC_POP, 32'hFFFF_FFFF, 3'd7);
    push_item(FUNC_POLL, 32'd0, 3'd7);
    push_item(FUNC_POLL, 32'd29, 3'd7);
    push_item(FUNC_POLL, 32'd30, 3'd7);
    push_item(FUNC_POLL, 32'd830, 3'd7);
    push_item(FUNC_POLL, 32'd3030, 3'd7);
    push_item(FUNC_POP, 32'd0, 3'd0);
    push_item(FUNC_POLL, 32'd3031, 3'd0);
    push_item(FUNC_POLL, 32'd3061, 3'd0);
    // action bounces once, then a short press
    push_item(FUNC_POLL, 32'd3100, 3'd4);
    push_item(FUNC_POLL, 32'd3110, 3'd0);
    push_item(FUNC_POLL, 32'd3120, 3'd4);
    push_item(FUNC_POLL, 32'd3150, 3'd4);
    push_item(FUNC_POLL, 32'd3160, 3'd0);
    push_item(FUNC_POLL, 32'd3190, 3'd0);
    push_item(FUNC_POLL, 32'd3190, 3'd1);
    push_item(FUNC_POLL, 32'd3220, 3'd1);
    push_item(FUNC_POP, 32'h5555_5555, 3'd2);
    push_item(FUNC_POP, 32'hAAAA_AAAA, 3'd5);
    push_item(FUNC_POP, 32'd0, 3'd0);
    gen_now = 32'd3300;
    gen_target = 3'd1;
    add_random(280);
    wait_idle();

    set_times(16'd3, 16'd12, 16'd25, 1'b0);
    add_random(300);
    wait_idle();

    // zero times pass at once
    set_times(16'd0, 16'd0, 16'd0, 1'b1);
    add_random(250);
    wait_idle();

    // longest times, running across the counter wrap
    set_times(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    gen_now = 32'hFFFF_F000;
    add_random(200);
    wait_idle();

    set_times(16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
              16'($urandom_range(0, 1200)), 1'b1);
    add_random(250);
    wait_idle();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== button_debounce_event_queue.f =====
src/bde_pkg.sv
src/bde_ram.sv
src/bde_lane.sv
src/bde_merge.sv
src/button_debounce_event_queue.sv
src/bde_checker.sv
tb/sv/tb.sv
